// ===== rtl/pphist_pkg.sv =====
package pphist_pkg;

   // Field widths of the transaction payloads
   localparam int TIME_W = 32;
   localparam int IVL_W  = 17;
   localparam int PORT_W = 16;
   localparam int OUT_W  = 32;

   // Iteration count of the remainder unit, one dividend bit per cycle
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Command codes
   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

endpackage

// ===== rtl/port_packet_histogram.sv =====
// Per-port packet histogram. Counters live in one single-port-write,
// registered-read memory of PORT_COUNT entries of COUNT_BITS bits. A read
// transaction presents the address, then takes the registered read data.
// A count transaction reads the source, writes the source while reading the
// destination, then writes the destination; equal ports are forwarded so
// they add two. Counters saturate. A count transaction with new_interval
// set first sweeps the memory to zero, one entry per cycle, while the
// interval start remainder is computed in a serial unit. After reset the
// same sweep runs before the first transaction is accepted; configuration
// writes are taken at any time. Ports at or above PORT_COUNT are not
// counted and read as zero.
module port_packet_histogram #(
   parameter int PORT_COUNT = 65536,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic                          req_new_interval,
   input  logic [pphist_pkg::TIME_W-1:0] req_time_seconds,
   input  logic [pphist_pkg::PORT_W-1:0] req_source_port,
   input  logic [pphist_pkg::PORT_W-1:0] req_destination_port,
   input  logic [pphist_pkg::PORT_W-1:0] req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pphist_pkg::OUT_W-1:0]  rsp_interval_start,
   output logic [pphist_pkg::OUT_W-1:0]  rsp_port_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pphist_pkg::IVL_W-1:0]  csr_interval_seconds
);

   import pphist_pkg::*;

   localparam int ADDR_W = $clog2(PORT_COUNT);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SRC,
      ST_SRC_WB,
      ST_DST_WB,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [IVL_W-1:0]      ivl_ff, ivl_in;
   logic [TIME_W-1:0]     begin_ff, begin_in;
   logic [ADDR_W-1:0]     clr_ptr_ff, clr_ptr_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [PORT_W-1:0]     src_ff, src_in;
   logic [PORT_W-1:0]     dst_ff, dst_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [COUNT_BITS-1:0] src_new_ff, src_new_in;
   logic [OUT_W-1:0]      pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_start_ff, rsp_start_in;
   logic [OUT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  slot_free;
   logic                  clr_done;
   logic                  src_ok;
   logic                  dst_ok;
   logic                  fwd;
   logic [COUNT_BITS-1:0] dst_old;
   logic [COUNT_BITS-1:0] src_sat;
   logic [COUNT_BITS-1:0] dst_sat;
   logic [OUT_W-1:0]      rd_conv;
   logic [OUT_W-1:0]      result;

   logic                  div_start;
   logic                  div_busy;
   logic [IVL_W-1:0]      div_rem;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [COUNT_BITS-1:0] mem_wr_data;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [COUNT_BITS-1:0] mem_rd_data;

   pphist_ram #(
      .DEPTH (PORT_COUNT),
      .WIDTH (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pphist_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_time_seconds),
      .divisor   (ivl_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   // Clamp wide counters to the output width
   generate
      if (COUNT_BITS > OUT_W) begin : g_wide
         assign rd_conv = (|mem_rd_data[COUNT_BITS-1:OUT_W]) ? '1 : mem_rd_data[OUT_W-1:0];
      end else begin : g_narrow
         assign rd_conv = OUT_W'(mem_rd_data);
      end
   endgenerate

   // Handshake and helper terms
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign clr_done  = (clr_ptr_ff == ADDR_W'(PORT_COUNT - 1));
   assign src_ok    = (32'(src_ff) < PORT_COUNT);
   assign dst_ok    = (32'(dst_ff) < PORT_COUNT);
   assign fwd       = src_ok && (src_ff == dst_ff);
   assign dst_old   = fwd ? src_new_ff : mem_rd_data;
   assign src_sat   = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;
   assign dst_sat   = (dst_old == '1) ? dst_old : dst_old + 1'b1;
   assign div_start = accept && (req_command == CMD_COUNT) && req_new_interval;

   // Drive the memory port by sequencer state
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ptr_ff;
      mem_wr_data = '0;
      mem_rd_addr = src_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_IDLE: begin
            mem_rd_addr = (req_command == CMD_READ) ? req_read_index[ADDR_W-1:0]
                                                    : req_source_port[ADDR_W-1:0];
         end
         ST_SRC_WB: begin
            mem_wr_en   = src_ok;
            mem_wr_addr = src_ff[ADDR_W-1:0];
            mem_wr_data = src_sat;
            mem_rd_addr = dst_ff[ADDR_W-1:0];
         end
         ST_DST_WB: begin
            mem_wr_en   = dst_ok;
            mem_wr_addr = dst_ff[ADDR_W-1:0];
            mem_wr_data = dst_sat;
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state and result staging
   always_comb begin
      state_in     = state_ff;
      ivl_in       = ivl_ff;
      begin_in     = begin_ff;
      clr_ptr_in   = clr_ptr_ff;
      time_in      = time_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rd_ok_in     = rd_ok_ff;
      src_new_in   = src_new_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_count_in = rsp_count_ff;
      result       = '0;

      // Drop a delivered result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Take a configuration write
      if (csr_valid) begin
         ivl_in = csr_interval_seconds;
      end

      unique case (state_ff)
         ST_INIT: begin
            if (clr_done) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               time_in  = req_time_seconds;
               src_in   = req_source_port;
               dst_in   = req_destination_port;
               rd_ok_in = (32'(req_read_index) < PORT_COUNT);
               if (req_command == CMD_READ) begin
                  state_in = ST_READ;
               end else if (req_new_interval) begin
                  clr_ptr_in = '0;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_SRC_WB;
               end
            end
         end
         ST_CLEAR: begin
            if (!clr_done) begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end else if (!div_busy) begin
               begin_in = time_ff - TIME_W'(div_rem);
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            state_in = ST_SRC_WB;
         end
         ST_SRC_WB: begin
            src_new_in = src_sat;
            state_in   = ST_DST_WB;
         end
         ST_DST_WB, ST_READ, ST_HOLD: begin
            if (state_ff == ST_READ) begin
               result = rd_ok_ff ? rd_conv : '0;
            end else if (state_ff == ST_HOLD) begin
               result = pend_ff;
            end
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = begin_ff;
               rsp_count_in = result;
               state_in     = ST_IDLE;
            end else begin
               pend_in  = result;
               state_in = ST_HOLD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ivl_ff       <= IVL_W'(1);
         begin_ff     <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ivl_ff       <= ivl_in;
         begin_ff     <= begin_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff      <= time_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      rd_ok_ff     <= rd_ok_in;
      src_new_ff   <= src_new_in;
      pend_ff      <= pend_in;
      rsp_start_ff <= rsp_start_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_start = rsp_start_ff;
   assign rsp_port_count     = rsp_count_ff;
   assign csr_ready          = 1'b1;

endmodule

// ===== rtl/pphist_ram.sv =====
module pphist_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pphist_div.sv =====
module pphist_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pphist_pkg::TIME_W-1:0] dividend,
   input  logic [pphist_pkg::IVL_W-1:0]  divisor,
   output logic                        busy,
   output logic [pphist_pkg::IVL_W-1:0]  remainder
);

   import pphist_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TIME_W-1:0]    dvd_ff, dvd_in;
   logic [IVL_W-1:0]     dsr_ff, dsr_in;
   logic [IVL_W-1:0]     rem_ff, rem_in;
   logic [IVL_W:0]       trial;

   // One restoring step per cycle; a zero divisor acts as one
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[TIME_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = (divisor == '0) ? IVL_W'(1) : divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = IVL_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[IVL_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule
